@@ rtl/lkdp_pkg.sv @@
// package for the kick-drift-kick particle update: constants, register codes, lane types
// no dependencies
`default_nettype none
package lkdp_pkg;
  localparam int FracBits  = 16;
  localparam int WordWidth = 32;

  localparam logic [2:0] RegForceScale = 3'd0;
  localparam logic [2:0] RegDragCoeff  = 3'd1;
  localparam logic [2:0] RegHalfStep   = 3'd2;
  localparam logic [2:0] RegFullStep   = 3'd3;
  localparam logic [2:0] RegBoxLength  = 3'd4;
  localparam logic [2:0] RegPeriodic   = 3'd5;
  localparam logic [2:0] RegDensity    = 3'd6;

  localparam logic [1:0] CmdKickDrift = 2'd0;
  localparam logic [1:0] CmdKick      = 2'd1;
  localparam logic [1:0] CmdEstimate  = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic       periodic;
  } lane_ctrl_t;
endpackage
`default_nettype wire

@@ rtl/lkdp_mulq.sv @@
// signed fixed-point multiply: round half away from zero, clip to word width
// depends on nothing
`default_nettype none
module lkdp_mulq #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic signed [W-1:0] a_i,
  input  wire logic signed [W-1:0] b_i,
  output logic signed [W-1:0]      p_o,
  output logic                     clip_o
);
  logic          neg;
  logic [W-1:0]  ua, ub;
  logic [2*W:0]  prod;
  logic [2*W:0]  mag;
  logic [2*W:0]  lim;
  always_comb begin
    neg  = a_i[W-1] ^ b_i[W-1];
    ua   = a_i[W-1] ? W'(-a_i) : W'(a_i);
    ub   = b_i[W-1] ? W'(-b_i) : W'(b_i);
    prod = (2*W+1)'(ua) * (2*W+1)'(ub);
    mag  = (prod + ((2*W+1)'(1) << (F-1))) >> F;
    lim  = ((2*W+1)'(1) << (W-1)) - (neg ? '0 : (2*W+1)'(1));
    clip_o = mag > lim;
    if (clip_o) mag = lim;
    p_o = neg ? W'(-mag) : W'(mag);
  end
endmodule
`default_nettype wire

@@ rtl/lkdp_lane.sv @@
// one component lane: acceleration, kick, drift and periodic wrap in turn
// depends on lkdp_pkg and lkdp_mulq
`default_nettype none
module lkdp_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire lkdp_pkg::lane_ctrl_t   ctrl_i,
  input  wire logic signed [W-1:0]    pos_i,
  input  wire logic signed [W-1:0]    vel_i,
  input  wire logic signed [W-1:0]    force_i,
  input  wire logic signed [W-1:0]    force_scale_i,
  input  wire logic signed [W-1:0]    drag_i,
  input  wire logic [30:0]            half_i,
  input  wire logic [30:0]            full_i,
  input  wire logic [30:0]            box_i,
  output logic                        done_o,
  output logic signed [W-1:0]         pos_o,
  output logic signed [W-1:0]         vel_o,
  output logic signed [W-1:0]         acc_o,
  output logic                        clip_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_FORCE, S_DRAG, S_KICK, S_DRIFT, S_WRAP
  } state_e;
  state_e state_q;
  logic signed [W-1:0] x_q, v_q, f_q, fa_q, acc_q;
  logic clip_q;
  logic signed [W-1:0] ma, mb, mp;
  logic mclip;
  lkdp_pkg::lane_ctrl_t ctrl_q;
  logic signed [W+1:0] sum, box_s;
  logic signed [W-1:0] sumsat;
  logic sumclip;
  localparam logic signed [W+1:0] SMax = (W+2)'((64'sd1 <<< (W-1)) - 1);
  localparam logic signed [W+1:0] SMin = -SMax - 1;

  lkdp_mulq #(.W(W), .F(F)) u_mul (.a_i(ma), .b_i(mb), .p_o(mp), .clip_o(mclip));

  always_comb begin
    ma = f_q; mb = force_scale_i; sum = '0;
    box_s = (W+2)'(box_i);
    case (state_q)
      S_FORCE: begin ma = force_scale_i; mb = f_q; end
      S_DRAG:  begin
        ma = drag_i; mb = v_q;
        sum = (W+2)'(fa_q) - (W+2)'(mp);
      end
      S_KICK:  begin
        ma = acc_q; mb = W'(half_i);
        sum = (W+2)'(v_q) + (W+2)'(mp);
      end
      S_DRIFT: begin
        ma = v_q; mb = W'(full_i);
        sum = (W+2)'(x_q) + (W+2)'(mp);
      end
      default: ;
    endcase
    sumclip = (sum > SMax) || (sum < SMin);
    sumsat  = (sum > SMax) ? W'(SMax) : ((sum < SMin) ? W'(SMin) : W'(sum));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: if (start_i) begin
          x_q <= pos_i; v_q <= vel_i; f_q <= force_i;
          ctrl_q <= ctrl_i; clip_q <= 1'b0;
          state_q <= S_FORCE;
        end
        S_FORCE: begin
          fa_q <= mp; clip_q <= clip_q | mclip; state_q <= S_DRAG;
        end
        S_DRAG: begin
          acc_q <= sumsat; clip_q <= clip_q | mclip | sumclip;
          state_q <= S_KICK;
        end
        S_KICK: begin
          if (ctrl_q.cmd == lkdp_pkg::CmdKickDrift || ctrl_q.cmd == lkdp_pkg::CmdKick) begin
            v_q <= sumsat; clip_q <= clip_q | mclip | sumclip;
          end
          state_q <= S_DRIFT;
        end
        S_DRIFT: begin
          if (ctrl_q.cmd == lkdp_pkg::CmdKickDrift) begin
            x_q <= sumsat; clip_q <= clip_q | mclip | sumclip;
          end
          state_q <= S_WRAP;
        end
        S_WRAP: begin
          if (ctrl_q.cmd != lkdp_pkg::CmdKick && ctrl_q.periodic) begin
            if (x_q[W-1]) begin
              if ((W+2)'(x_q) + box_s >= box_s) x_q <= W'((W+2)'(x_q));
              else x_q <= W'((W+2)'(x_q) + box_s);
            end else if ((W+2)'(x_q) >= box_s) begin
              x_q <= W'((W+2)'(x_q) - box_s);
            end
          end
          done_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign pos_o = x_q;
  assign vel_o = v_q;
  assign acc_o = acc_q;
  assign clip_o = clip_q;
endmodule
`default_nettype wire

@@ rtl/lkdp_error.sv @@
// merging stage: acceleration magnitude, cube-root mass term and error quotient
// depends on nothing; iterative sqrt and divide one step per cycle, cube root steps square then compare
`default_nettype none
module lkdp_error #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic signed [W-1:0] ax_i,
  input  wire logic signed [W-1:0] ay_i,
  input  wire logic signed [W-1:0] az_i,
  input  wire logic [31:0]         mass_i,
  input  wire logic [30:0]         dens_i,
  output logic                     done_o,
  output logic [W-1:0]             err_o,
  output logic                     clip_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_SQRT, S_CBRT, S_DIV, S_OUT
  } state_e;
  state_e state_q;
  logic [W-1:0]  ab_q [3];
  logic [5:0]    s_q;
  logic [1:0]    k_q;
  logic [63:0]   sum_q, n_q, r_q, bit_q;
  logic [63:0]   p_q;
  logic [30:0]   lo_q, hi_q;
  logic          ph_q;
  logic [59:0]   sq_q;
  logic [63:0]   mag_q;
  logic [127:0]  num_q;
  logic [64:0]   rem_q;
  logic [127:0]  q_q;
  logic [7:0]    cnt_q;
  logic [W-1:0]  mx;
  logic [29:0]   mid;
  logic [92:0]   cube;
  logic [31:0]   t;
  logic [64:0]   rem_n;
  localparam logic [127:0] EMax = (128'd1 << W) - 1;

  always_comb begin
    mx = ab_q[0];
    if (ab_q[1] > mx) mx = ab_q[1];
    if (ab_q[2] > mx) mx = ab_q[2];
    mid  = 30'(lo_q + ((hi_q - lo_q) >> 1));
    // square registered first, cube built from two narrow products
    cube = ((93'(sq_q[59:30]) * 93'(mid)) << 30) + (93'(sq_q[29:0]) * 93'(mid));
    t    = 32'(ab_q[k_q] >> s_q);
    rem_n = {rem_q[63:0], num_q[127]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: if (start_i) begin
          ab_q[0] <= ax_i[W-1] ? W'(-ax_i) : W'(ax_i);
          ab_q[1] <= ay_i[W-1] ? W'(-ay_i) : W'(ay_i);
          ab_q[2] <= az_i[W-1] ? W'(-az_i) : W'(az_i);
          p_q <= 64'(mass_i) * 64'(dens_i);
          s_q <= '0; k_q <= '0; sum_q <= '0; clip_o <= 1'b0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          if (64'(mx >> s_q) >= 64'h8000_0000) s_q <= s_q + 6'd1;
          else begin
            sum_q <= sum_q + 64'(t) * 64'(t);
            if (k_q == 2'd2) begin
              n_q <= sum_q + 64'(t) * 64'(t); r_q <= '0; bit_q <= 64'd1 << 62;
              state_q <= S_SQRT;
            end else k_q <= k_q + 2'd1;
          end
        end
        S_SQRT: begin
          if (bit_q == '0) begin
            mag_q <= r_q << s_q;
            lo_q <= '0; hi_q <= 31'h4000_0000; ph_q <= 1'b0;
            state_q <= S_CBRT;
          end else if (bit_q > n_q && r_q == '0) bit_q <= bit_q >> 2;
          else begin
            if (n_q >= r_q + bit_q) begin
              n_q <= n_q - r_q - bit_q; r_q <= (r_q >> 1) + bit_q;
            end else r_q <= r_q >> 1;
            bit_q <= bit_q >> 2;
          end
        end
        S_CBRT: begin
          if (hi_q - lo_q > 31'd1) begin
            if (!ph_q) begin
              sq_q <= 60'(mid) * 60'(mid); ph_q <= 1'b1;
            end else begin
              if (cube <= (93'(p_q) << F)) lo_q <= {1'b0, mid};
              else hi_q <= {1'b0, mid};
              ph_q <= 1'b0;
            end
          end else begin
            num_q <= 128'(mag_q) << F; rem_q <= '0; q_q <= '0; cnt_q <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (mag_q == '0) begin
            err_o <= '0; state_q <= S_OUT;
          end else if (lo_q == '0) begin
            err_o <= W'(EMax); clip_o <= 1'b1; state_q <= S_OUT;
          end else begin
            num_q <= num_q << 1;
            if (rem_n >= 65'(lo_q)) begin
              rem_q <= rem_n - 65'(lo_q); q_q <= {q_q[126:0], 1'b1};
            end else begin
              rem_q <= rem_n; q_q <= {q_q[126:0], 1'b0};
            end
            cnt_q <= cnt_q + 8'd1;
            if (cnt_q == 8'd127) state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (mag_q != '0 && lo_q != '0) begin
            if (q_q > EMax) begin
              err_o <= W'(EMax); clip_o <= 1'b1;
            end else err_o <= W'(q_q);
          end
          done_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/leapfrog_kick_drift_particle_top.sv @@
// top level of the kick-drift-kick particle update: config, three lanes, error merge
// depends on lkdp_pkg, lkdp_lane, lkdp_error
`default_nettype none
// channel | direction | handshake
// in      | input     | in_valid_i / in_stall_o
// out     | output    | out_valid_o / out_stall_i
// cfg     | input     | cfg_we_i, cfg_idx_i, cfg_data_i
// one request at a time: the lanes run, then the error unit sets the pace: magnitude
// (an extra shift step when a component reaches 2^31), sqrt, cube root (square,
// then compare, per search step), divide (cut short with zero acceleration), out
// the input is free again in the same cycle as the result becomes valid
// reset clears control and the peak; config registers return to their reset values
// a result waits in the output register while out_stall_i is high; the next request
// is taken meanwhile and, once done, waits until the output register is free
module leapfrog_kick_drift_particle_top #(
  parameter int FRAC_BITS  = lkdp_pkg::FracBits,
  parameter int WORD_WIDTH = lkdp_pkg::WordWidth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic signed [31:0] pos_x_i, pos_y_i, pos_z_i,
  input  wire logic signed [31:0] vel_x_i, vel_y_i, vel_z_i,
  input  wire logic signed [31:0] force_x_i, force_y_i, force_z_i,
  input  wire logic [31:0] mass_i,
  input  wire logic        restart_max_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] new_pos_x_o, new_pos_y_o, new_pos_z_o,
  output logic signed [31:0] new_vel_x_o, new_vel_y_o, new_vel_z_o,
  output logic [31:0]      step_error_o,
  output logic [31:0]      error_peak_o,
  output logic             saturated_o
);
  localparam int W = WORD_WIDTH;
  typedef enum logic [1:0] {S_IDLE, S_LANES, S_ERR, S_WAIT} state_e;
  state_e state_q;

  logic signed [31:0] fscale_q, drag_q;
  logic [30:0] half_q, full_q, box_q, dens_q;
  logic periodic_q;
  logic [31:0] peak_q;
  logic restart_q, inclip_q;
  logic [31:0] mass_q;
  logic [2:0] ldone;
  logic lanes_go, err_go, err_done, err_clip;
  logic signed [W-1:0] lpos [3], lvel [3], lacc [3], lp [3], lv [3], lf [3];
  logic [2:0] lclip;
  logic [W-1:0] err;
  lkdp_pkg::lane_ctrl_t ctrl;
  logic signed [31:0] ip [3], iv [3], ifc [3];
  logic [2:0] inclip;
  logic out_free, load_out;
  logic [31:0] peak_base, peak_next;

  // input words clipped to the word width
  function automatic logic signed [W-1:0] clipw(input logic signed [31:0] v,
                                                 output logic c);
    logic signed [63:0] e, mx, mn;
    e  = 64'(v);
    mx = (64'sd1 <<< (W-1)) - 1;
    mn = -mx - 1;
    c  = (e > mx) || (e < mn);
    return (e > mx) ? W'(mx) : ((e < mn) ? W'(mn) : W'(e));
  endfunction

  assign ip  = '{pos_x_i, pos_y_i, pos_z_i};
  assign iv  = '{vel_x_i, vel_y_i, vel_z_i};
  assign ifc = '{force_x_i, force_y_i, force_z_i};
  logic [2:0] c1, c2, c3;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lp[k] = clipw(ip[k], c1[k]);
      lv[k] = clipw(iv[k], c2[k]);
      lf[k] = clipw(ifc[k], c3[k]);
    end
    inclip = c1 | c2 | c3;
  end

  assign ctrl.cmd = cmd_i;
  assign ctrl.periodic = periodic_q;
  assign in_stall_o = (state_q != S_IDLE);
  assign lanes_go = in_valid_i && !in_stall_o;

  // output register can take a new result when empty or being drained
  assign out_free = !out_valid_o || !out_stall_i;
  assign load_out = ((state_q == S_ERR && err_done) || state_q == S_WAIT) && out_free;

  // peak update with optional restart
  always_comb begin
    peak_base = restart_q ? '0 : peak_q;
    peak_next = (32'(err) > peak_base) ? 32'(err) : peak_base;
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    lkdp_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk_i, .rst_ni, .start_i(lanes_go), .ctrl_i(ctrl),
      .pos_i(lp[k]), .vel_i(lv[k]), .force_i(lf[k]),
      .force_scale_i(W'(fscale_q)), .drag_i(W'(drag_q)),
      .half_i(half_q), .full_i(full_q), .box_i(box_q),
      .done_o(ldone[k]), .pos_o(lpos[k]), .vel_o(lvel[k]), .acc_o(lacc[k]),
      .clip_o(lclip[k]));
  end

  assign err_go = (state_q == S_LANES) && ldone[0];
  lkdp_error #(.W(W), .F(FRAC_BITS)) u_err (
    .clk_i, .rst_ni, .start_i(err_go), .ax_i(lacc[0]), .ay_i(lacc[1]),
    .az_i(lacc[2]), .mass_i(mass_q), .dens_i(dens_q),
    .done_o(err_done), .err_o(err), .clip_o(err_clip));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; out_valid_o <= 1'b0; peak_q <= '0;
      fscale_q <= 32'sd65536; drag_q <= '0; half_q <= 31'd32768;
      full_q <= 31'd65536; box_q <= 31'd65536; periodic_q <= 1'b0;
      dens_q <= 31'd65536;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lkdp_pkg::RegForceScale: fscale_q <= cfg_data_i;
          lkdp_pkg::RegDragCoeff:  drag_q <= cfg_data_i;
          lkdp_pkg::RegHalfStep:   half_q <= cfg_data_i[30:0];
          lkdp_pkg::RegFullStep:   full_q <= cfg_data_i[30:0];
          lkdp_pkg::RegBoxLength:  box_q <= cfg_data_i[30:0];
          lkdp_pkg::RegPeriodic:   periodic_q <= cfg_data_i[0];
          lkdp_pkg::RegDensity:    dens_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: if (lanes_go) begin
          mass_q <= mass_i; restart_q <= restart_max_i; inclip_q <= |inclip;
          state_q <= S_LANES;
        end
        S_LANES: if (ldone[0]) state_q <= S_ERR;
        // a finished request waits in S_WAIT while the previous result is still held
        S_ERR: if (err_done) state_q <= out_free ? S_IDLE : S_WAIT;
        S_WAIT: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      if (load_out) begin
        peak_q <= peak_next;
        error_peak_o <= peak_next;
        step_error_o <= 32'(err);
        saturated_o <= inclip_q | (|lclip) | err_clip;
        new_pos_x_o <= 32'(lpos[0]); new_pos_y_o <= 32'(lpos[1]);
        new_pos_z_o <= 32'(lpos[2]);
        new_vel_x_o <= 32'(lvel[0]); new_vel_y_o <= 32'(lvel[1]);
        new_vel_z_o <= 32'(lvel[2]);
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  a_lanes_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ldone[0] |-> ldone[1] && ldone[2]) else $error("lanes out of step");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(step_error_o))
    else $error("stalled result changed");
  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_peak_o >= step_error_o) else $error("peak below error");
endmodule
`default_nettype wire
